// ===== rtl/core/fpfa_pkg.sv =====
`default_nettype none

package fpfa_pkg;

  // Table geometry.
  localparam int MAX_PARTITIONS = 16;
  localparam int SIZE_BITS      = 16;
  localparam int IDX_W          = $clog2(MAX_PARTITIONS);
  localparam int CNT_W          = $clog2(MAX_PARTITIONS + 1);

  // Configuration port geometry.
  localparam int CFG_IDX_W  = 1;
  localparam int CFG_DATA_W = 5;

  // Configuration register indexes.
  localparam logic [CFG_IDX_W-1:0] REG_FIT_POLICY      = 1'd0;
  localparam logic [CFG_IDX_W-1:0] REG_PARTITION_COUNT = 1'd1;

  // Fit policy codes; the unused code acts as first fit.
  localparam logic [1:0] POLICY_FIRST = 2'd0;
  localparam logic [1:0] POLICY_BEST  = 2'd1;
  localparam logic [1:0] POLICY_WORST = 2'd2;

  // Operation codes.
  localparam logic OP_LOAD    = 1'b0;
  localparam logic OP_REQUEST = 1'b1;

  // Reset value of the partition count register.
  localparam logic [4:0] COUNT_RESET = 5'd16;

  typedef struct packed {
    logic        op;
    logic [3:0]  partition_index;
    logic [15:0] item_size;
    logic        final_request;
  } in_item_t;

  typedef struct packed {
    logic       granted;
    logic [3:0] granted_index;
  } out_item_t;

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_SCAN,
    ST_DONE
  } state_t;

endpackage

`default_nettype wire

// ===== rtl/core/fixed_partition_fit_allocator.sv =====
`default_nettype none

// Fixed partition allocator with first, best and worst fit. A load transaction
// writes one partition size and frees that partition in the cycle it is taken,
// and produces no result. A request transaction walks the partition table one
// entry per cycle through one shared compare unit, stopping early when first fit
// finds a free partition, and the input is stalled until the result
// transaction is taken. A request flagged final frees every partition once its
// result is taken. Sizes of partitions never loaded are unknown; scanning them
// gives an unspecified result.
module fixed_partition_fit_allocator
  import fpfa_pkg::*;
(
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_stall,
  input  wire in_item_t              in_item,
  output logic                       out_valid,
  input  wire logic                  out_stall,
  output out_item_t                  out_item,
  input  wire logic                  cfg_we,
  input  wire logic [CFG_IDX_W-1:0]  cfg_index,
  input  wire logic [CFG_DATA_W-1:0] cfg_wdata
);

  state_t                state_r, state_nxt;
  logic [1:0]            policy_r;
  logic [4:0]            count_r;
  logic [SIZE_BITS-1:0]  size_mem [MAX_PARTITIONS];
  logic [MAX_PARTITIONS-1:0] used_r;
  logic [SIZE_BITS-1:0]  req_size_r;
  logic                  final_r;
  logic [CNT_W-1:0]      limit_r;
  logic [CNT_W-1:0]      scan_r;
  logic                  found_r;
  logic [IDX_W-1:0]      pick_r;
  logic [SIZE_BITS-1:0]  best_r;
  logic [SIZE_BITS-1:0]  cur_size_r;
  out_item_t             out_r;

  logic                  in_fire, out_fire, load_fire, req_fire;
  logic                  cur_fits, cur_better, take, scan_stop, first_fit;
  logic [CNT_W-1:0]      limit_nxt;
  logic [CNT_W-1:0]      scan_nxt;

  assign in_fire   = in_valid && !in_stall;
  assign out_fire  = out_valid && !out_stall;
  assign load_fire = in_fire && (in_item.op == OP_LOAD);
  assign req_fire  = in_fire && (in_item.op == OP_REQUEST);

  // Saturate the partition count to the table depth.
  always_comb begin
    if (count_r > CNT_W'(MAX_PARTITIONS)) begin
      limit_nxt = CNT_W'(MAX_PARTITIONS);
    end else begin
      limit_nxt = count_r[CNT_W-1:0];
    end
  end

  // Configuration registers.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      policy_r <= POLICY_FIRST;
      count_r  <= COUNT_RESET;
    end else if (cfg_we) begin
      case (cfg_index)
        REG_FIT_POLICY:      policy_r <= cfg_wdata[1:0];
        REG_PARTITION_COUNT: count_r  <= cfg_wdata[4:0];
        default: begin
        end
      endcase
    end
  end

  // Scan pointer: restarts on a request and advances until the scan stops.
  always_comb begin
    scan_nxt = scan_r;
    if (req_fire) begin
      scan_nxt = '0;
    end else if ((state_r == ST_SCAN) && !scan_stop) begin
      scan_nxt = scan_r + CNT_W'(1);
    end
  end

  // Partition size table; no reset, entries are defined by loads. The entry at
  // the next scan position is read into a register so it lines up with the
  // pointer.
  always_ff @(posedge clk) begin
    if (load_fire && (32'(in_item.partition_index) < MAX_PARTITIONS)) begin
      size_mem[in_item.partition_index[IDX_W-1:0]] <=
        in_item.item_size[SIZE_BITS-1:0];
    end
    cur_size_r <= size_mem[scan_nxt[IDX_W-1:0]];
  end

  // Shared compare unit over the entry under the scan pointer.
  assign cur_fits = (scan_r < limit_r) && !used_r[scan_r[IDX_W-1:0]] &&
                    (cur_size_r >= req_size_r);

  always_comb begin
    first_fit = 1'b0;
    case (policy_r)
      POLICY_BEST:  cur_better = cur_size_r < best_r;
      POLICY_WORST: cur_better = cur_size_r > best_r;
      default: begin
        cur_better = 1'b0;
        first_fit  = 1'b1;
      end
    endcase
  end

  assign take      = cur_fits && (!found_r || cur_better);
  assign scan_stop = (scan_r == limit_r) || (found_r && first_fit);

  // Next state.
  always_comb begin
    state_nxt = state_r;
    case (state_r)
      ST_IDLE: if (req_fire)  state_nxt = ST_SCAN;
      ST_SCAN: if (scan_stop) state_nxt = ST_DONE;
      ST_DONE: if (out_fire)  state_nxt = ST_IDLE;
      default:                state_nxt = ST_IDLE;
    endcase
  end

  // Handshake outputs.
  always_comb begin
    in_stall  = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: in_stall  = 1'b0;
      ST_DONE: out_valid = 1'b1;
      default: begin
      end
    endcase
  end

  assign out_item = out_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r <= ST_IDLE;
    end else begin
      state_r <= state_nxt;
    end
  end

  // Scan sequencer: pointer, running pick and result register.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      scan_r  <= '0;
      found_r <= 1'b0;
      pick_r  <= '0;
    end else begin
      scan_r <= scan_nxt;
      if (req_fire) begin
        found_r <= 1'b0;
        pick_r  <= '0;
      end else if ((state_r == ST_SCAN) && !scan_stop && take) begin
        found_r <= 1'b1;
        pick_r  <= scan_r[IDX_W-1:0];
      end
    end
  end

  always_ff @(posedge clk) begin
    if (req_fire) begin
      req_size_r <= in_item.item_size[SIZE_BITS-1:0];
      final_r    <= in_item.final_request;
      limit_r    <= limit_nxt;
    end
    if ((state_r == ST_SCAN) && !scan_stop && take) begin
      best_r <= cur_size_r;
    end
    if ((state_r == ST_SCAN) && scan_stop) begin
      out_r.granted       <= found_r;
      out_r.granted_index <= 4'(pick_r);
    end
  end

  // Used marks: freed by a load, set by a grant, all freed after a final result.
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      used_r <= '0;
    end else if (out_fire && final_r) begin
      used_r <= '0;
    end else if ((state_r == ST_SCAN) && scan_stop && found_r) begin
      used_r[pick_r] <= 1'b1;
    end else if (load_fire && (32'(in_item.partition_index) < MAX_PARTITIONS)) begin
      used_r[in_item.partition_index[IDX_W-1:0]] <= 1'b0;
    end
  end

  // The scan pointer never passes the latched limit.
  a_scan_bound: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_SCAN) |-> (scan_r <= limit_r))
    else $error("scan pointer beyond partition limit");

  // A granted partition is already marked used while its result waits.
  a_grant_marked: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && out_item.granted) |-> used_r[out_item.granted_index[IDX_W-1:0]])
    else $error("granted partition not marked used");

  // A refused request reports index zero.
  a_refuse_index: assert property (@(posedge clk) disable iff (!rst_n)
    (out_valid && !out_item.granted) |-> (out_item.granted_index == 4'd0))
    else $error("refused request carries nonzero index");

  // Taking a final result frees every partition.
  a_final_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (out_fire && final_r) |=> (used_r == '0))
    else $error("final request did not free partitions");

  // No input is taken while a result is pending.
  a_no_overlap: assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall)
    else $error("input accepted while result pending");

endmodule

`default_nettype wire
